// ===== sv/memory_bank_decoder_macros.svh =====
// assertion macros for the memory bank decoder checks
`ifndef MEMORY_BANK_DECODER_MACROS_SVH
`define MEMORY_BANK_DECODER_MACROS_SVH

// same-cycle implication, masked while reset is low
`define MBD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("memory bank decoder check failed");

// next-cycle implication, masked while reset is low
`define MBD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("memory bank decoder check failed");

// next-cycle implication that also holds across reset
`define MBD_ASSERT_NEXT_ALWAYS(label, ante, cons) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("memory bank decoder check failed");

`endif

// ===== sv/mbd_pkg.sv =====
package mbd_pkg;

    localparam int CMD_W    = 3;
    localparam int ADDR_W   = 16;
    localparam int PORT_W   = 8;
    localparam int TARGET_W = 3;
    localparam int OFFSET_W = 18;

    // request command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_MEM_RD  = 3'd0,
        CMD_MEM_WR  = 3'd1,
        CMD_PORT_A  = 3'd2,
        CMD_PORT_B  = 3'd3,
        CMD_PORT_84 = 3'd4,
        CMD_PORT_86 = 3'd5
    } t_cmd;

    // decode targets
    typedef enum logic [TARGET_W-1:0] {
        TGT_RAM    = 3'd0,
        TGT_VRAM   = 3'd1,
        TGT_OSROM  = 3'd2,
        TGT_BASIC  = 3'd3,
        TGT_MODULE = 3'd4
    } t_target;

    // configuration register indexes
    localparam logic REG_MACHINE_MODEL  = 1'b0;
    localparam logic REG_BASIC_ROM_KIND = 1'b1;

    // register reset values
    localparam logic [1:0] MODEL_RESET = 2'd1;
    localparam logic [1:0] BASIC_RESET = 2'd1;
    localparam logic [1:0] BASIC_ABSENT = 2'd0;

    // bank latch reset values
    localparam logic [PORT_W-1:0] PORT_A_RESET  = 8'h0f;
    localparam logic [PORT_W-1:0] PORT_B_RESET  = 8'hf1;

endpackage

// ===== sv/mbd_req_if.sv =====
interface mbd_req_if;
    logic                       valid;
    logic                       ready;
    logic [mbd_pkg::CMD_W-1:0]  command;
    logic [mbd_pkg::ADDR_W-1:0] cpu_address;
    logic [mbd_pkg::PORT_W-1:0] port_value;

    modport source (output valid, command, cpu_address, port_value, input ready);
    modport sink   (input valid, command, cpu_address, port_value, output ready);
endinterface

// ===== sv/mbd_rsp_if.sv =====
interface mbd_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [mbd_pkg::TARGET_W-1:0] target;
    logic [mbd_pkg::OFFSET_W-1:0] physical_offset;
    logic                         write_lands;

    modport source (output valid, target, physical_offset, write_lands, input ready);
    modport sink   (input valid, target, physical_offset, write_lands, output ready);
endinterface

// ===== sv/memory_bank_decoder.sv =====
// memory bank decoder: cpu access to target, offset and write flag
// a memory access passes the input register, then the result register, on its way to the result beat
// throughput: one request per cycle; port writes give no result and never stall
// only a stalled result register holding back a memory access slows the request side
// reset: synchronous active low; bank latches and config registers take their defaults,
// both pipeline stages empty
module memory_bank_decoder (
    input  logic         i_clk,
    input  logic         i_rst_n,
    mbd_req_if.sink      req,
    mbd_rsp_if.source    rsp,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import mbd_pkg::*;

    // configuration registers
    logic [1:0] r_machine_model;
    logic [1:0] r_basic_rom_kind;

    // bank latches
    logic [PORT_W-1:0] r_port_a;
    logic [PORT_W-1:0] r_port_b;
    logic [PORT_W-1:0] r_port_84;
    logic [PORT_W-1:0] r_port_86;

    // input stage
    logic              r_s1_valid;
    logic [CMD_W-1:0]  r_s1_cmd;
    logic [ADDR_W-1:0] r_s1_addr;
    logic [PORT_W-1:0] r_s1_val;

    // result stage
    logic                r_out_valid;
    t_target             r_out_target;
    logic [OFFSET_W-1:0] r_out_offset;
    logic                r_out_wl;

    // decode results
    t_target             n_target;
    logic [OFFSET_W-1:0] n_offset;
    logic                n_wl;

    logic s1_is_mem;
    logic out_free;
    logic s1_go;
    logic cfg_wr;
    logic four;
    logic [1:0] basic_bank;

    // apb side
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_BASIC_ROM_KIND) begin
            prdata[1:0] = r_basic_rom_kind;
        end else begin
            prdata[1:0] = r_machine_model;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_machine_model  <= MODEL_RESET;
            r_basic_rom_kind <= BASIC_RESET;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_MACHINE_MODEL) begin
                r_machine_model <= pwdata[1:0];
            end else begin
                r_basic_rom_kind <= pwdata[1:0];
            end
        end
    end

    // pipeline flow control
    assign s1_is_mem = r_s1_cmd inside {CMD_MEM_RD, CMD_MEM_WR};
    assign out_free  = !r_out_valid || rsp.ready;
    assign s1_go     = r_s1_valid && (!s1_is_mem || out_free);
    assign req.ready = !r_s1_valid || s1_go;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (req.ready) begin
            r_s1_valid <= req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (req.ready && req.valid) begin
            r_s1_cmd  <= req.command;
            r_s1_addr <= req.cpu_address;
            r_s1_val  <= req.port_value;
        end
    end

    // bank latch updates as port writes leave the input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_port_a  <= PORT_A_RESET;
            r_port_b  <= PORT_B_RESET;
            r_port_84 <= '0;
            r_port_86 <= '0;
        end else if (s1_go) begin
            case (r_s1_cmd)
                CMD_PORT_A:  r_port_a  <= r_s1_val;
                CMD_PORT_B:  r_port_b  <= r_s1_val;
                CMD_PORT_84: r_port_84 <= r_s1_val;
                CMD_PORT_86: r_port_86 <= r_s1_val;
                default: ;
            endcase
        end
    end

    // address decode
    assign four       = (r_machine_model != 2'd0);
    assign basic_bank = (four && r_basic_rom_kind[1]) ? r_port_86[6:5] : 2'b00;

    always_comb begin
        n_target = TGT_MODULE;
        n_offset = {2'b00, r_s1_addr};
        n_wl     = 1'b1;
        case (r_s1_addr[15:14])
            // ram0 window
            2'b00: begin
                if (r_port_a[1]) begin
                    n_target = TGT_RAM;
                    n_wl     = r_port_a[3];
                end
            end
            // ram4 window
            2'b01: begin
                if (four && r_port_86[0]) begin
                    n_target = TGT_RAM;
                    n_wl     = r_port_86[1];
                end
            end
            // video ram or ram8 window
            2'b10: begin
                if (r_port_a[2]) begin
                    n_target = TGT_VRAM;
                    n_wl     = 1'b1;
                    if (four && (r_s1_addr < 16'ha800)) begin
                        n_offset = {2'b00, r_port_84[2], r_port_84[1], r_s1_addr[13:0]};
                    end else begin
                        n_offset = {4'b0000, r_s1_addr[13:0]};
                    end
                end else if (four && r_port_b[5]) begin
                    n_target = TGT_RAM;
                    n_wl     = r_port_b[6];
                    if (r_machine_model[1]) begin
                        n_offset = {r_port_84[7:4], r_s1_addr[13:0]};
                    end else begin
                        n_offset = {2'b00, 1'b1, r_port_84[4], r_s1_addr[13:0]};
                    end
                end
            end
            // rom windows
            default: begin
                if (!r_s1_addr[13]) begin
                    if (four && r_port_86[7]) begin
                        n_target = TGT_OSROM;
                        n_offset = {5'b00000, r_s1_addr[12:0]};
                        n_wl     = 1'b0;
                    end else if (r_port_a[7] && (r_basic_rom_kind != BASIC_ABSENT)) begin
                        n_target = TGT_BASIC;
                        n_offset = {3'b000, basic_bank, r_s1_addr[12:0]};
                        n_wl     = 1'b0;
                    end
                end else if (r_port_a[0]) begin
                    n_target = TGT_OSROM;
                    n_offset = {4'b0000, 1'b1, r_s1_addr[12:0]};
                    n_wl     = 1'b0;
                end
            end
        endcase
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_go && s1_is_mem) begin
            r_out_valid <= 1'b1;
        end else if (rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && s1_is_mem) begin
            r_out_target <= n_target;
            r_out_offset <= n_offset;
            r_out_wl     <= n_wl;
        end
    end

    assign rsp.valid           = r_out_valid;
    assign rsp.target          = r_out_target;
    assign rsp.physical_offset = r_out_offset;
    assign rsp.write_lands     = r_out_wl;

endmodule

// ===== sv/mbd_checker.sv =====
`include "memory_bank_decoder_macros.svh"

module mbd_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_rsp_valid,
    input logic                         i_rsp_ready,
    input logic [mbd_pkg::TARGET_W-1:0] i_target,
    input logic [mbd_pkg::OFFSET_W-1:0] i_offset,
    input logic                         i_write_lands
);
    import mbd_pkg::*;

    // a stalled result beat holds its payload
    `MBD_ASSERT_NEXT(a_rsp_hold, i_rsp_valid && !i_rsp_ready, i_rsp_valid && $stable(i_target) && $stable(i_offset) && $stable(i_write_lands))

    // no result comes straight out of reset
    `MBD_ASSERT_NEXT_ALWAYS(a_reset_empty, !i_rst_n, !i_rsp_valid)

    // rom targets never take writes
    `MBD_ASSERT_NOW(a_rom_readonly, i_rsp_valid && (i_target == TGT_OSROM || i_target == TGT_BASIC), !i_write_lands)

    // module bus passes the cpu address through and always takes writes
    `MBD_ASSERT_NOW(a_module_pass, i_rsp_valid && i_target == TGT_MODULE, i_write_lands && i_offset[17:16] == 2'b00)

    // target code stays in range
    `MBD_ASSERT_NOW(a_target_range, i_rsp_valid, i_target <= TGT_MODULE)

endmodule

bind memory_bank_decoder mbd_checker u_mbd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_rsp_valid   (rsp.valid),
    .i_rsp_ready   (rsp.ready),
    .i_target      (rsp.target),
    .i_offset      (rsp.physical_offset),
    .i_write_lands (rsp.write_lands)
);

// ===== tb/mbd_decode_checker.sv =====
`timescale 1ns / 1ps

module mbd_decode_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mbd_req_if          req_mon,
    mbd_rsp_if          rsp_mon,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output int          o_mismatches,
    output int          o_pending,
    output int          o_decodes,
    output int          o_port_writes,
    output int          o_ignored
);
    import mbd_pkg::*;

    typedef struct packed {
        t_target               target;
        logic [OFFSET_W-1:0]   offset;
        logic                  write_lands;
    } t_decode;

    // expected decodes, oldest first
    t_decode expected_decodes[$];

    // shadow copy of the configuration and the bank latches
    logic [1:0]        cfg_model;
    logic [1:0]        cfg_basic;
    logic [PORT_W-1:0] latch_a;
    logic [PORT_W-1:0] latch_b;
    logic [PORT_W-1:0] latch_84;
    logic [PORT_W-1:0] latch_86;

    // address decode for one cpu access under the current latches
    function automatic t_decode decode_access(input logic [ADDR_W-1:0] a);
        t_decode           d;
        logic              four;
        logic [ADDR_W-1:0] rel;
        logic [OFFSET_W-1:0] base;
        logic [1:0]        bank;
        four = (cfg_model != 2'd0);
        d.target = TGT_MODULE;
        d.offset = {2'b00, a};
        d.write_lands = 1'b1;
        if (a < 16'h4000) begin
            // ram0 window
            if (latch_a[1]) begin
                d.target = TGT_RAM;
                d.write_lands = latch_a[3];
            end
        end else if (a < 16'h8000) begin
            // ram4 window, four-series only
            if (four && latch_86[0]) begin
                d.target = TGT_RAM;
                d.write_lands = latch_86[1];
            end
        end else if (a < 16'hc000) begin
            rel = a - 16'h8000;
            if (latch_a[2]) begin
                // video ram, paged below a800 on four-series
                d.target = TGT_VRAM;
                d.write_lands = 1'b1;
                if (four && a < 16'ha800)
                    d.offset = {2'b00, latch_84[2:1], rel[13:0]};
                else
                    d.offset = {2'b00, rel};
            end else if (four && latch_b[5]) begin
                // ram8 block
                if (cfg_model[1])
                    base = {latch_84[7:4], 14'b0};
                else
                    base = 18'h08000 + {3'b000, latch_84[4], 14'b0};
                d.target = TGT_RAM;
                d.offset = base + {2'b00, rel};
                d.write_lands = latch_b[6];
            end
        end else if (a < 16'he000) begin
            rel = a - 16'hc000;
            if (four && latch_86[7]) begin
                d.target = TGT_OSROM;
                d.offset = {2'b00, rel};
                d.write_lands = 1'b0;
            end else if (latch_a[7] && cfg_basic != BASIC_ABSENT) begin
                // basic rom, banked only for the 32k image on four-series
                bank = 2'b00;
                if (four && cfg_basic[1])
                    bank = latch_86[6:5];
                d.target = TGT_BASIC;
                d.offset = {3'b000, bank, 13'b0} + {2'b00, rel};
                d.write_lands = 1'b0;
            end
        end else begin
            if (latch_a[0]) begin
                d.target = TGT_OSROM;
                d.offset = 18'h02000 + {2'b00, a - 16'he000};
                d.write_lands = 1'b0;
            end
        end
        return d;
    endfunction

    always @(posedge i_clk) begin : monitor
        t_decode want;
        if (!i_rst_n) begin
            cfg_model = MODEL_RESET;
            cfg_basic = BASIC_RESET;
            latch_a   = PORT_A_RESET;
            latch_b   = PORT_B_RESET;
            latch_84  = '0;
            latch_86  = '0;
            expected_decodes.delete();
            o_mismatches  = 0;
            o_decodes     = 0;
            o_port_writes = 0;
            o_ignored     = 0;
        end else begin
            // result beat against the oldest expectation
            if (rsp_mon.valid && rsp_mon.ready) begin
                if (expected_decodes.size() == 0) begin
                    $display("%0t: result beat with nothing expected: target %0d offset %h wl %b",
                             $time, rsp_mon.target, rsp_mon.physical_offset,
                             rsp_mon.write_lands);
                    o_mismatches++;
                end else begin
                    want = expected_decodes.pop_front();
                    o_decodes++;
                    if (rsp_mon.target !== want.target) begin
                        $display("%0t: target mismatch: expected %0d got %0d",
                                 $time, want.target, rsp_mon.target);
                        o_mismatches++;
                    end
                    if (rsp_mon.physical_offset !== want.offset) begin
                        $display("%0t: offset mismatch: expected %h got %h",
                                 $time, want.offset, rsp_mon.physical_offset);
                        o_mismatches++;
                    end
                    if (rsp_mon.write_lands !== want.write_lands) begin
                        $display("%0t: write_lands mismatch: expected %b got %b",
                                 $time, want.write_lands, rsp_mon.write_lands);
                        o_mismatches++;
                    end
                end
            end

            // register writes on the config port
            if (psel && penable && pwrite && pready) begin
                if (paddr[2] == REG_MACHINE_MODEL)
                    cfg_model = pwdata[1:0];
                else if (paddr[2] == REG_BASIC_ROM_KIND)
                    cfg_basic = pwdata[1:0];
            end

            // request beat: decode or latch update
            if (req_mon.valid && req_mon.ready) begin
                case (req_mon.command)
                    CMD_MEM_RD, CMD_MEM_WR: begin
                        expected_decodes.push_back(decode_access(req_mon.cpu_address));
                    end
                    CMD_PORT_A: begin
                        latch_a = req_mon.port_value;
                        o_port_writes++;
                    end
                    CMD_PORT_B: begin
                        latch_b = req_mon.port_value;
                        o_port_writes++;
                    end
                    CMD_PORT_84: begin
                        latch_84 = req_mon.port_value;
                        o_port_writes++;
                    end
                    CMD_PORT_86: begin
                        latch_86 = req_mon.port_value;
                        o_port_writes++;
                    end
                    default: begin
                        o_ignored++;
                    end
                endcase
            end
        end
        o_pending = expected_decodes.size();
    end

endmodule

// ===== tb/tb_memory_bank_decoder.sv =====
`timescale 1ns / 1ps

module tb_memory_bank_decoder;
    import mbd_pkg::*;

    localparam int CLK_HALF          = 5;
    localparam int WATCHDOG_LIMIT    = 2000;
    localparam int SETTLE_CYCLES     = 4;
    localparam int HOLD_OFF_CYCLES   = 80;
    localparam int N_SETTINGS        = 16;
    localparam int ITEMS_PER_SETTING = 105;
    localparam int HOLD_SETTING      = 6;

    // command codes the block ignores
    localparam logic [CMD_W-1:0] CMD_UNUSED_6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_UNUSED_7 = 3'd7;

    // window boundaries of the cpu address map
    localparam logic [ADDR_W-1:0] WINDOW_EDGES [12] = '{
        16'h0000, 16'h3fff, 16'h4000, 16'h7fff, 16'h8000, 16'ha7ff,
        16'ha800, 16'hbfff, 16'hc000, 16'hdfff, 16'he000, 16'hffff
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel, penable, pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int mismatches, pending, decodes, port_writes, ignored;

    bit src_gaps    = 1'b0;
    bit sink_stalls = 1'b0;
    bit hold_req    = 1'b0;
    int idle_cycles = 0;

    mbd_req_if req();
    mbd_rsp_if rsp();

    memory_bank_decoder DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .req     (req),
        .rsp     (rsp),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    mbd_decode_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .req_mon       (req),
        .rsp_mon       (rsp),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .pready        (pready),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .o_mismatches  (mismatches),
        .o_pending     (pending),
        .o_decodes     (decodes),
        .o_port_writes (port_writes),
        .o_ignored     (ignored)
    );

    // clock
    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // watchdog on cycles without any beat
    always @(posedge i_clk) begin
        if (!i_rst_n || (req.valid && req.ready) || (rsp.valid && rsp.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog: no beat for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("FAIL");
            $finish;
        end
    end

    // mostly short gaps, a few long ones
    function automatic int gap_length();
        if ($urandom_range(0, 19) < 17)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [ADDR_W-1:0] pick_address();
        if ($urandom_range(0, 1) == 0)
            return WINDOW_EDGES[$urandom_range(0, 11)];
        return ADDR_W'($urandom);
    endfunction

    // result side: random stalls plus one long hold-off on request
    initial begin : result_sink
        rsp.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                rsp.ready = 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
            end else if (sink_stalls && $urandom_range(0, 3) == 0) begin
                rsp.ready = 1'b0;
                repeat (gap_length()) @(negedge i_clk);
            end else begin
                rsp.ready = 1'b1;
            end
        end
    end

    // one request beat; called and returns at a falling edge
    task automatic send_beat(input logic [CMD_W-1:0] cmd, input logic [ADDR_W-1:0] addr,
                             input logic [PORT_W-1:0] value);
        int gap;
        gap = (src_gaps && $urandom_range(0, 3) == 0) ? gap_length() : 0;
        if (gap > 0) begin
            req.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req.valid       = 1'b1;
        req.command     = cmd;
        req.cpu_address = addr;
        req.port_value  = value;
        @(posedge i_clk);
        while (!req.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_random_item(input bit access_only, output bit counted);
        int r;
        logic [CMD_W-1:0] cmd;
        r = $urandom_range(0, 99);
        if (access_only || r < 60) begin
            cmd = $urandom_range(0, 1) ? CMD_MEM_WR : CMD_MEM_RD;
        end else if (r < 95) begin
            case ($urandom_range(0, 3))
                0: cmd = CMD_PORT_A;
                1: cmd = CMD_PORT_B;
                2: cmd = CMD_PORT_84;
                default: cmd = CMD_PORT_86;
            endcase
        end else begin
            cmd = $urandom_range(0, 1) ? CMD_UNUSED_7 : CMD_UNUSED_6;
        end
        send_beat(cmd, pick_address(), PORT_W'($urandom));
        counted = (cmd != CMD_UNUSED_6) && (cmd != CMD_UNUSED_7);
    endtask

    // stop offering and wait for every decode to come back
    task automatic drain_results();
        req.valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic apb_write(input logic reg_index, input logic [1:0] value);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = {reg_index, 2'b00};
        pwdata  = ($urandom & ~32'h3) | {30'b0, value};
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    initial begin : stimulus
        bit counted;
        int sent;
        int hold_left;
        req.valid       = 1'b0;
        req.command     = CMD_MEM_RD;
        req.cpu_address = '0;
        req.port_value  = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: window edges, every command, paging and rom cases at reset config
        send_beat(CMD_MEM_RD, 16'h0000, 8'h00);
        send_beat(CMD_MEM_WR, 16'hffff, 8'hff);
        send_beat(CMD_MEM_RD, 16'h4000, 8'h5a);
        send_beat(CMD_MEM_RD, 16'h8000, 8'ha5);
        send_beat(CMD_PORT_84, 16'hffff, 8'hf6);
        send_beat(CMD_MEM_RD, 16'ha7ff, 8'h00);
        send_beat(CMD_MEM_RD, 16'ha800, 8'h00);
        send_beat(CMD_MEM_WR, 16'hbfff, 8'h00);
        send_beat(CMD_PORT_A, 16'h0000, 8'h8b);
        send_beat(CMD_MEM_WR, 16'h8000, 8'h00);
        send_beat(CMD_MEM_RD, 16'hc000, 8'h00);
        send_beat(CMD_PORT_86, 16'h1234, 8'h63);
        send_beat(CMD_MEM_WR, 16'h7fff, 8'h00);
        send_beat(CMD_MEM_RD, 16'hdfff, 8'h00);
        send_beat(CMD_PORT_86, 16'h0000, 8'h80);
        send_beat(CMD_MEM_RD, 16'hc000, 8'h00);
        send_beat(CMD_PORT_B, 16'hffff, 8'h00);
        send_beat(CMD_MEM_RD, 16'h8000, 8'h00);
        send_beat(CMD_PORT_A, 16'h0000, 8'h00);
        send_beat(CMD_MEM_WR, 16'h0000, 8'h00);
        send_beat(CMD_MEM_RD, 16'he000, 8'h00);
        send_beat(CMD_UNUSED_6, 16'hffff, 8'hff);
        send_beat(CMD_UNUSED_7, 16'h0000, 8'h00);
        send_beat(CMD_PORT_A, 16'h0000, 8'hff);
        send_beat(CMD_PORT_B, 16'h0000, 8'hff);
        send_beat(CMD_MEM_RD, 16'hffff, 8'h00);

        // random items over every model and basic rom setting
        for (int p = 0; p < N_SETTINGS; p++) begin
            drain_results();
            apb_write(REG_MACHINE_MODEL, 2'(p / 4));
            apb_write(REG_BASIC_ROM_KIND, 2'(p % 4));
            src_gaps    = (p % 3 != 0);
            sink_stalls = (p % 4 != 1);
            sent = 0;
            hold_left = 0;
            while (sent < ITEMS_PER_SETTING) begin
                if (p == HOLD_SETTING && sent == 20 && hold_left == 0) begin
                    hold_req  = 1'b1;
                    hold_left = 30;
                end
                if (p % 2 == 0 && sent == ITEMS_PER_SETTING / 2)
                    drain_results();
                send_random_item(hold_left > 0, counted);
                if (hold_left > 0)
                    hold_left--;
                if (counted)
                    sent++;
            end
        end
        drain_results();

        $display("covered %0d decoded accesses, %0d port writes, %0d ignored commands",
                 decodes, port_writes, ignored);
        $display("across %0d model and basic rom settings, with random stalls and a hold-off",
                 N_SETTINGS);
        if (mismatches == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== memory_bank_decoder.f =====
+incdir+sv
sv/mbd_pkg.sv
sv/mbd_req_if.sv
sv/mbd_rsp_if.sv
sv/memory_bank_decoder.sv
sv/mbd_checker.sv
tb/mbd_decode_checker.sv
tb/tb_memory_bank_decoder.sv
